>>> sv/rdsc_pkg.sv
package rdsc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_REQ_RATE     = 3'd0;
    localparam logic [2:0] REG_DEADBAND     = 3'd1;
    localparam logic [2:0] REG_ANGLE_OFFSET = 3'd2;
    localparam logic [2:0] REG_LOOP_GAIN    = 3'd3;
    localparam logic [2:0] REG_FAKE_MODE    = 3'd4;

    localparam int CFG_DATA_W = 23;
    localparam int DIV_STEPS  = 27;

    localparam int DAY_MS     = 86400000;
    localparam int FULL_TURN  = 36000;
    localparam int JUMP_LIMIT = 30000;
    localparam int RAMP_STEP  = 120;
    localparam int MS_PER_S   = 1000;
    localparam int S24_MAX    = 8388607;
    localparam int S24_MIN    = -8388608;

    typedef struct packed {
        logic [15:0] position;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
        logic [4:0]  day_of_month;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        beam_angle;
        logic signed [23:0] scan_rate;
        logic               rate_valid;
        logic signed [23:0] drive_cmd;
        logic               drive_updated;
        logic [15:0]        sweep_count;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic rate;
        logic mul;
        logic acc;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

    // saturate to 24 bits signed
    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > S24_MAX)
            r = 24'sd8388607;
        else if (v < S24_MIN)
            r = -24'sd8388608;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

>>> sv/rdsc_if.sv
interface rdsc_in_if;
    logic               valid;
    logic               ready;
    rdsc_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rdsc_out_if;
    logic                valid;
    logic                ready;
    rdsc_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/rdsc_ctrl.sv
module rdsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rdsc_pkg::status_t status,
    output rdsc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RATE,
        S_MUL,
        S_ACC,
        S_EMIT
    } state_t;

    state_t     state_reg;
    logic [4:0] count_reg;

    assign in_ready = (state_reg == S_IDLE);

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.div_step = (state_reg == S_DIV);
        cmd.rate     = (state_reg == S_RATE);
        cmd.mul      = (state_reg == S_MUL);
        cmd.acc      = (state_reg == S_ACC);
        cmd.emit     = (state_reg == S_EMIT) && status.out_free;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DIV;
                        count_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    count_reg <= count_reg + 5'd1;
                    if (count_reg == 5'(rdsc_pkg::DIV_STEPS - 1))
                        state_reg <= S_RATE;
                end
                S_RATE:  state_reg <= S_MUL;
                S_MUL:   state_reg <= S_ACC;
                S_ACC:   state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (status.out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/rdsc_dp.sv
module rdsc_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [rdsc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  rdsc_pkg::in_item_t              in_data,
    input  rdsc_pkg::cmd_t                  cmd,
    output rdsc_pkg::status_t               status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rdsc_pkg::out_item_t             out_data
);

    // configuration
    logic signed [22:0] req_rate_reg;
    logic [21:0]        deadband_reg;
    logic signed [16:0] angle_offset_reg;
    logic [15:0]        loop_gain_reg;
    logic               fake_mode_reg;

    // state carried between requests
    logic [26:0]        last_ms_reg;
    logic [4:0]         last_day_reg;
    logic [15:0]        last_pos_reg;
    logic [15:0]        last_angle_reg;
    logic [15:0]        sweep_reg;
    logic signed [23:0] drive_reg;
    logic [15:0]        ramp_reg;
    logic signed [23:0] held_rate_reg;

    // per request working registers
    logic [15:0]        angle_reg;
    logic               valid_reg;
    logic               sign_reg;
    logic [26:0]        quo_reg;
    logic [27:0]        rem_reg;
    logic [27:0]        divisor_reg;
    logic signed [24:0] err_reg;
    logic               upd_reg;
    logic signed [41:0] prod_reg;
    logic               out_valid_reg;
    rdsc_pkg::out_item_t out_reg;

    // load stage combinational values
    logic [26:0]        now_ms;
    logic [16:0]        ramp_next;
    logic [15:0]        pos_u;
    logic signed [18:0] ang0;
    logic signed [18:0] ang1;
    logic signed [18:0] ang2;
    logic signed [18:0] ang3;
    logic [15:0]        angle_next;
    logic signed [28:0] elapsed;
    logic signed [17:0] pdiff;
    logic signed [17:0] moved;
    logic signed [27:0] dividend;
    logic [26:0]        dividend_mag;
    logic [27:0]        elapsed_mag;
    logic signed [16:0] adiff;
    logic [16:0]        adiff_mag;
    logic [17:0]        pdiff_mag;

    // divider step
    logic [28:0]        rem_shift;
    logic               fits;

    // rate and drive
    logic signed [27:0] rate_wide;
    logic signed [23:0] rate;
    logic signed [24:0] err;
    logic signed [24:0] db_s;
    logic signed [41:0] prod_round;
    logic signed [25:0] term;
    logic signed [26:0] drive_sum;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

    // time of day, ramp, angle, elapsed time and unwrap
    always_comb
    begin
        now_ms = 27'(in_data.millisecond) + 27'(rdsc_pkg::MS_PER_S) *
                 (27'(in_data.second) + 27'd60 *
                 (27'(in_data.minute) + 27'd60 * 27'(in_data.hour)));

        ramp_next = 17'(ramp_reg) + 17'(rdsc_pkg::RAMP_STEP);
        if (ramp_next > 17'(rdsc_pkg::FULL_TURN))
            ramp_next = '0;
        pos_u = fake_mode_reg ? ramp_next[15:0] : in_data.position;

        ang0 = $signed({3'b000, pos_u}) - 19'(angle_offset_reg);
        ang1 = (ang0 > 19'sd36000) ? ang0 - 19'sd36000 : ang0;
        ang2 = (ang1 < 19'sd0) ? ang1 + 19'sd36000 : ang1;
        if (ang2 > 19'sd36000)
            ang3 = 19'sd36000;
        else if (ang2 < 19'sd0)
            ang3 = 19'sd0;
        else
            ang3 = ang2;
        angle_next = ang3[15:0];

        elapsed = $signed({2'b00, now_ms}) - $signed({2'b00, last_ms_reg});
        if (last_day_reg != in_data.day_of_month)
            elapsed = elapsed + 29'(rdsc_pkg::DAY_MS);

        pdiff     = $signed({2'b00, pos_u}) - $signed({2'b00, last_pos_reg});
        pdiff_mag = pdiff[17] ? 18'(-pdiff) : 18'(pdiff);
        moved     = pdiff;
        if (pdiff_mag > 18'(rdsc_pkg::JUMP_LIMIT))
        begin
            if (req_rate_reg > 23'sd0)
                moved = pdiff + 18'sd36000;
            else
                moved = pdiff - 18'sd36000;
        end

        dividend     = 28'(moved) * 28'sd1000;
        dividend_mag = dividend[27] ? 27'(-dividend) : dividend[26:0];
        elapsed_mag  = elapsed[28] ? 28'(-elapsed) : elapsed[27:0];

        adiff     = $signed({1'b0, angle_next}) - $signed({1'b0, last_angle_reg});
        adiff_mag = adiff[16] ? 17'(-adiff) : 17'(adiff);
    end

    // one restoring divide step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[26]};
        fits      = (rem_shift >= {1'b0, divisor_reg});
    end

    // rate, error and drive update
    always_comb
    begin
        rate_wide  = sign_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        rate       = rdsc_pkg::sat24(32'(rate_wide));
        err        = 25'(req_rate_reg) - 25'(rate);
        db_s       = $signed({3'b000, deadband_reg});
        prod_round = prod_reg[41] ? prod_reg + 42'sd65535 : prod_reg;
        term       = prod_round[41:16];
        drive_sum  = 27'(drive_reg) + 27'(term);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_rate_reg     <= '0;
            deadband_reg     <= '0;
            angle_offset_reg <= '0;
            loop_gain_reg    <= '0;
            fake_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rdsc_pkg::REG_REQ_RATE:     req_rate_reg     <= cfg_data[22:0];
                rdsc_pkg::REG_DEADBAND:     deadband_reg     <= cfg_data[21:0];
                rdsc_pkg::REG_ANGLE_OFFSET: angle_offset_reg <= cfg_data[16:0];
                rdsc_pkg::REG_LOOP_GAIN:    loop_gain_reg    <= cfg_data[15:0];
                rdsc_pkg::REG_FAKE_MODE:    fake_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // state kept across requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ms_reg    <= '0;
            last_day_reg   <= '0;
            last_pos_reg   <= '0;
            last_angle_reg <= '0;
            sweep_reg      <= '0;
            drive_reg      <= '0;
            ramp_reg       <= '0;
            held_rate_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_ms_reg    <= now_ms;
                last_day_reg   <= in_data.day_of_month;
                last_pos_reg   <= pos_u;
                last_angle_reg <= angle_next;
                if (fake_mode_reg)
                    ramp_reg <= ramp_next[15:0];
                if (adiff_mag > 17'(rdsc_pkg::JUMP_LIMIT))
                    sweep_reg <= sweep_reg + 16'd1;
            end
            if (cmd.rate && valid_reg)
                held_rate_reg <= rate;
            if (cmd.acc && upd_reg)
                drive_reg <= rdsc_pkg::sat24(32'(drive_sum));
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            angle_reg   <= angle_next;
            valid_reg   <= (elapsed != 29'sd0);
            sign_reg    <= moved[17] ^ elapsed[28];
            quo_reg     <= dividend_mag;
            rem_reg     <= '0;
            divisor_reg <= elapsed_mag;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[25:0], fits};
            rem_reg <= fits ? 28'(rem_shift - {1'b0, divisor_reg}) : rem_shift[27:0];
        end
        if (cmd.rate)
        begin
            err_reg <= err;
            upd_reg <= valid_reg && ((err > db_s) || (err < -db_s));
        end
        if (cmd.mul)
            prod_reg <= err_reg * $signed({26'd0, loop_gain_reg});
        if (cmd.emit)
        begin
            out_reg.beam_angle    <= angle_reg;
            out_reg.scan_rate     <= held_rate_reg;
            out_reg.rate_valid    <= valid_reg;
            out_reg.drive_cmd     <= drive_reg;
            out_reg.drive_updated <= upd_reg;
            out_reg.sweep_count   <= sweep_reg;
        end
    end

    // output register handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

endmodule

>>> sv/rotodome_rate_loop_sweep_counter.sv
// channel   dir  payload
// in_ch     in   position, hour, minute, second, millisecond, day_of_month
// out_ch    out  beam_angle, scan_rate, rate_valid, drive_cmd, drive_updated,
//                sweep_count
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// one request at a time, taken only while the controller is idle: a load
// step, the steps of the bit-serial rate divider, then rate, gain multiply
// and drive update, and a step to hand the result to the output register
// a finished result waits in the output register while the next request
// is taken; a stalled output holds the controller in its emit step
// rst_n clears configuration, history, sweep and drive state at once
module rotodome_rate_loop_sweep_counter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [rdsc_pkg::CFG_DATA_W-1:0] cfg_data,
    rdsc_in_if.sink                         in_ch,
    rdsc_out_if.source                      out_ch
);

    rdsc_pkg::cmd_t    cmd;
    rdsc_pkg::status_t status;

    // sequencer
    rdsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    rdsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_ch.data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );

endmodule

>>> sv/rdsc_checker.sv
module rdsc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input rdsc_pkg::out_item_t out_data
);

    logic [1:0] pending_reg;

    // requests in flight or waiting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 2'((in_valid && in_ready) ? 1 : 0)
                           - 2'((out_valid && out_ready) ? 1 : 0);
    end

    // result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one request at a time into the loop
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken in consecutive cycles");

    // no result without a request
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without request");

    // no drive update without a valid rate
    a_drive_gated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.rate_valid |-> !out_data.drive_updated)
        else $error("drive updated with zero elapsed time");

endmodule

bind rotodome_rate_loop_sweep_counter rdsc_checker u_rdsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
